>>> rtl/core/srfp_pkg.sv
package srfp_pkg;

   // Frame layout and limits
   localparam int MAX_BUFFER_BYTES_DEF = 255;
   localparam int MIN_REPLY            = 5;
   localparam int ECHO_OVERHEAD        = 5;
   // Bytes of the echo already taken when its length byte arrives
   localparam int ECHO_SEEN_AT_LEN     = 2;
   localparam int SKIP_W               = 9;

   localparam logic [7:0] HOST_ADDRESS_RESET = 8'h02;

   // Reply offsets of the header bytes
   localparam logic [7:0] OFS_SOURCE  = 8'd0;
   localparam logic [7:0] OFS_LENGTH  = 8'd1;
   localparam logic [7:0] OFS_DEST    = 8'd2;
   localparam logic [7:0] OFS_HEADER  = 8'd3;
   localparam logic [7:0] OFS_PAYLOAD = 8'd4;
   localparam logic [7:0] REPLY_SAT   = 8'hFF;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_SHORT = 2'd1,
      STATUS_BAD_SUM   = 2'd2
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      status_type status;
      logic [7:0] source_address;
      logic [7:0] data_length;
      logic [7:0] dest_address;
      logic [7:0] header_code;
      logic [7:0] reply_length;
   } result_type;

endpackage

>>> rtl/core/srfp_frame.sv
module srfp_frame #(
   parameter int MaxBufferBytes = srfp_pkg::MAX_BUFFER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          rx_byte,
   input  logic                last_byte,
   input  logic                csr_we,
   input  logic [7:0]          csr_data,
   output logic                res_valid,
   output srfp_pkg::result_type res
);
   import srfp_pkg::*;

   localparam int PosW = $clog2(MaxBufferBytes + 1);

   logic [7:0]        host_ff;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic              echo_ff, echo_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic [7:0]        rp_ff, rp_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        src_ff, src_in;
   logic [7:0]        len_ff, len_in;
   logic [7:0]        dst_ff, dst_in;
   logic [7:0]        hdr_ff, hdr_in;
   logic [7:0]        pay_idx;
   logic              emit;
   result_type        res_c;

   assign pay_idx = rp_ff - OFS_PAYLOAD;

   // Work out the next frame state and the result of this byte
   always_comb begin
      pos_in  = pos_ff;
      echo_in = echo_ff;
      skip_in = skip_ff;
      rp_in   = rp_ff;
      sum_in  = sum_ff;
      src_in  = src_ff;
      len_in  = len_ff;
      dst_in  = dst_ff;
      hdr_in  = hdr_ff;
      emit    = 1'b0;
      res_c   = '0;
      if (take) begin
         // Bytes past the buffer limit are ignored
         if (pos_ff < PosW'(MaxBufferBytes)) begin
            pos_in = pos_ff + PosW'(1);
            if (pos_ff == PosW'(0) && rx_byte == host_ff) begin
               echo_in = 1'b1;
            end else if (echo_ff) begin
               if (pos_ff == PosW'(1)) begin
                  skip_in = {1'b0, rx_byte} + SKIP_W'(ECHO_OVERHEAD - ECHO_SEEN_AT_LEN);
               end else if (skip_ff != '0) begin
                  skip_in = skip_ff - SKIP_W'(1);
               end
               if (pos_ff != PosW'(0) && skip_in == '0) begin
                  echo_in = 1'b0;
               end
            end else begin
               case (rp_ff)
                  OFS_SOURCE: src_in = rx_byte;
                  OFS_LENGTH: len_in = rx_byte;
                  OFS_DEST:   dst_in = rx_byte;
                  OFS_HEADER: hdr_in = rx_byte;
                  default: ;
               endcase
               sum_in = sum_ff + rx_byte;
               if (rp_ff >= OFS_PAYLOAD && pay_idx < len_ff && !last_byte) begin
                  emit = 1'b1;
               end
               if (rp_ff != REPLY_SAT) begin
                  rp_in = rp_ff + 8'd1;
               end
            end
         end
         if (emit) begin
            res_c.kind          = KIND_PAYLOAD;
            res_c.payload_byte  = rx_byte;
            res_c.payload_index = pay_idx;
         end
         // Summarize the buffer on its final byte, then drop the frame state
         if (last_byte) begin
            res_c.kind           = KIND_SUMMARY;
            if (rp_in < 8'(MIN_REPLY)) begin
               res_c.status = STATUS_TOO_SHORT;
            end else if (sum_in == 8'd0) begin
               res_c.status = STATUS_OK;
            end else begin
               res_c.status = STATUS_BAD_SUM;
            end
            res_c.source_address = src_in;
            res_c.data_length    = len_in;
            res_c.dest_address   = dst_in;
            res_c.header_code    = hdr_in;
            res_c.reply_length   = rp_in;
            pos_in  = '0;
            echo_in = 1'b0;
            skip_in = '0;
            rp_in   = '0;
            sum_in  = '0;
            src_in  = '0;
            len_in  = '0;
            dst_in  = '0;
            hdr_in  = '0;
         end
      end
   end

   assign res_valid = take && (emit || last_byte);
   assign res       = res_c;

   // Hold the frame state and the host address
   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff <= HOST_ADDRESS_RESET;
         pos_ff  <= '0;
         echo_ff <= 1'b0;
         skip_ff <= '0;
         rp_ff   <= '0;
         sum_ff  <= '0;
         src_ff  <= '0;
         len_ff  <= '0;
         dst_ff  <= '0;
         hdr_ff  <= '0;
      end else begin
         if (csr_we) begin
            host_ff <= csr_data;
         end
         pos_ff  <= pos_in;
         echo_ff <= echo_in;
         skip_ff <= skip_in;
         rp_ff   <= rp_in;
         sum_ff  <= sum_in;
         src_ff  <= src_in;
         len_ff  <= len_in;
         dst_ff  <= dst_in;
         hdr_ff  <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   // A final byte always leaves a cleared frame behind
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (take && last_byte) |=> (pos_ff == '0 && rp_ff == 8'd0 && !echo_ff))
      else $error("frame state not cleared after final byte");

   // Reply bytes never outnumber buffer bytes
   a_rp_le_pos: assert property (@(posedge clock) disable iff (reset)
      (8'(pos_ff) >= rp_ff))
      else $error("reply position ahead of buffer position");

   // No reply byte is counted while the echo is being dropped
   a_echo_no_reply: assert property (@(posedge clock) disable iff (reset)
      (take && echo_ff && !last_byte) |=> $stable(rp_ff))
      else $error("reply advanced during echo");
`endif

endmodule

>>> rtl/core/srfp_queue.sv
module srfp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  srfp_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output srfp_pkg::result_type out_data
);
   import srfp_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full result queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/serial_reply_frame_parser_unit.sv
// Results are queued as their bytes are accepted; rsp_ offers the oldest first.
// Throughput: one byte per cycle while req_stall is low; the frame state
// updates once per byte. A two-entry result queue keeps req_ open while
// one result waits on rsp_. Reset (synchronous, active high) clears the
// frame state and the queue and sets the host address to 0x02.
module serial_reply_frame_parser_unit #(
   parameter int MaxBufferBytes = srfp_pkg::MAX_BUFFER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_source_address,
   output logic [7:0] rsp_data_length,
   output logic [7:0] rsp_dest_address,
   output logic [7:0] rsp_header_code,
   output logic [7:0] rsp_reply_length,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_host_address
);
   import srfp_pkg::*;

   logic       take;
   logic       res_valid;
   logic       full;
   result_type res;
   result_type head;

   assign req_stall = full;
   assign take      = req_valid && !full;
   assign csr_ready = 1'b1;

   srfp_frame #(
      .MaxBufferBytes(MaxBufferBytes)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .last_byte (req_last_byte),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_host_address),
      .res_valid (res_valid),
      .res       (res)
   );

   srfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   // Unpack the head transaction onto the result ports
   assign rsp_kind           = head.kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_payload_index  = head.payload_index;
   assign rsp_status         = head.status;
   assign rsp_source_address = head.source_address;
   assign rsp_data_length    = head.data_length;
   assign rsp_dest_address   = head.dest_address;
   assign rsp_header_code    = head.header_code;
   assign rsp_reply_length   = head.reply_length;

endmodule

>>> bench/serial_reply_frame_parser_unit_tb.sv
module serial_reply_frame_parser_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srfp_pkg::*;

   typedef logic [7:0] octet_queue[$];

   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_BYTES   = 355;
   localparam int LONG_PAYLOAD  = 250;
   localparam int SPILL_BYTES   = 5;

   // Tracks the frame state of the parser and the results it owes
   class reply_frame_model;
      logic [7:0] host_address;
      logic [7:0] buf_pos;
      bit         echo_active;
      logic [8:0] echo_left;
      logic [7:0] reply_pos;
      logic [7:0] byte_sum;
      logic [7:0] hdr_source;
      logic [7:0] hdr_length;
      logic [7:0] hdr_dest;
      logic [7:0] hdr_code;
      result_type owed_results[$];
      int         mismatches;

      function new();
         host_address = HOST_ADDRESS_RESET;
         mismatches   = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         buf_pos     = '0;
         echo_active = 1'b0;
         echo_left   = '0;
         reply_pos   = '0;
         byte_sum    = '0;
         hdr_source  = '0;
         hdr_length  = '0;
         hdr_dest    = '0;
         hdr_code    = '0;
      endfunction

      function void set_host(logic [7:0] value);
         host_address = value;
      endfunction

      // Advance the frame state by one accepted byte and queue what it owes
      function void take_rx_byte(logic [7:0] b, logic last);
         result_type r;
         logic [7:0] pos;
         logic [7:0] rp;
         bit         emit;
         r    = '0;
         emit = 1'b0;
         if (buf_pos < MAX_BUFFER_BYTES_DEF) begin
            pos     = buf_pos;
            buf_pos = pos + 8'd1;
            if (pos == 8'd0 && b == host_address) begin
               echo_active = 1'b1;
            end else if (echo_active) begin
               // length byte of the echo sets how many bytes are still to drop
               if (pos == 8'd1)
                  echo_left = 9'(b) + 9'(ECHO_OVERHEAD - ECHO_SEEN_AT_LEN);
               else if (echo_left != 9'd0)
                  echo_left = echo_left - 9'd1;
               if (pos != 8'd0 && echo_left == 9'd0)
                  echo_active = 1'b0;
            end else begin
               rp = reply_pos;
               case (rp)
                  OFS_SOURCE: hdr_source = b;
                  OFS_LENGTH: hdr_length = b;
                  OFS_DEST:   hdr_dest   = b;
                  OFS_HEADER: hdr_code   = b;
                  default: ;
               endcase
               byte_sum = byte_sum + b;
               if (rp >= OFS_PAYLOAD && 8'(rp - OFS_PAYLOAD) < hdr_length && !last) begin
                  r.kind          = KIND_PAYLOAD;
                  r.payload_byte  = b;
                  r.payload_index = 8'(rp - OFS_PAYLOAD);
                  emit            = 1'b1;
               end
               if (rp != REPLY_SAT)
                  reply_pos = rp + 8'd1;
            end
         end
         // final byte closes the buffer, even when it was past the limit
         if (last) begin
            r      = '0;
            r.kind = KIND_SUMMARY;
            if (reply_pos < MIN_REPLY)
               r.status = STATUS_TOO_SHORT;
            else if (byte_sum == 8'd0)
               r.status = STATUS_OK;
            else
               r.status = STATUS_BAD_SUM;
            r.source_address = hdr_source;
            r.data_length    = hdr_length;
            r.dest_address   = hdr_dest;
            r.header_code    = hdr_code;
            r.reply_length   = reply_pos;
            emit             = 1'b1;
            clear_frame();
         end
         if (emit)
            owed_results.push_back(r);
      endfunction

      function void check_field(string field, logic [7:0] want, logic [7:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, actual %0d", field, want, seen);
            mismatches++;
         end
      endfunction

      // Compare one delivered result against the oldest owed one
      function void match_result(result_type seen);
         result_type want;
         if (owed_results.size() == 0) begin
            $error("result with none owed: kind %0d", seen.kind);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         check_field("kind", want.kind, seen.kind);
         check_field("payload_byte", want.payload_byte, seen.payload_byte);
         check_field("payload_index", want.payload_index, seen.payload_index);
         check_field("status", want.status, seen.status);
         check_field("source_address", want.source_address, seen.source_address);
         check_field("data_length", want.data_length, seen.data_length);
         check_field("dest_address", want.dest_address, seen.dest_address);
         check_field("header_code", want.header_code, seen.header_code);
         check_field("reply_length", want.reply_length, seen.reply_length);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = '0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic       rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_index;
   logic [1:0] rsp_status;
   logic [7:0] rsp_source_address;
   logic [7:0] rsp_data_length;
   logic [7:0] rsp_dest_address;
   logic [7:0] rsp_header_code;
   logic [7:0] rsp_reply_length;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_host_address = '0;

   reply_frame_model model = new();

   int sender_idle_pct = 33;
   int recv_idle_pct   = 87;
   int bytes_sent      = 0;
   int hold_requests   = 0;
   int holds_served    = 0;
   int hold_left       = 0;

   serial_reply_frame_parser_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_status         (rsp_status),
      .rsp_source_address (rsp_source_address),
      .rsp_data_length    (rsp_data_length),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_header_code    (rsp_header_code),
      .rsp_reply_length   (rsp_reply_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_host_address   (csr_host_address)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (holds_served != hold_requests) begin
         hold_left = HOLD_CYCLES;
         holds_served++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Check every result transaction
   always @(posedge clock) begin
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind           = kind_type'(rsp_kind);
         seen.payload_byte   = rsp_payload_byte;
         seen.payload_index  = rsp_payload_index;
         seen.status         = status_type'(rsp_status);
         seen.source_address = rsp_source_address;
         seen.data_length    = rsp_data_length;
         seen.dest_address   = rsp_dest_address;
         seen.header_code    = rsp_header_code;
         seen.reply_length   = rsp_reply_length;
         model.match_result(seen);
      end
   end

   // Offer one byte, wait for its transaction, then return on the falling edge
   task automatic push_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      model.take_rx_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_buffer(input octet_queue q);
      foreach (q[i])
         push_byte(q[i], i == q.size() - 1);
   endtask

   // Drop valid and let every owed result drain
   task automatic settle_block();
      req_valid <= 1'b0;
      while (model.owed_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_host_address(input logic [7:0] value);
      csr_valid        <= 1'b1;
      csr_host_address <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      model.set_host(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void append_checksum(ref octet_queue q);
      logic [7:0] sum;
      sum = '0;
      foreach (q[i])
         sum = sum + q[i];
      q.push_back(8'(-sum));
   endfunction

   function automatic logic [7:0] pick_source(input logic [7:0] host);
      logic [7:0] src;
      src = 8'($urandom);
      while (src == host)
         src = 8'($urandom);
      return src;
   endfunction

   // Mostly well-formed buffers with random content, some noise and broken ones
   function automatic void build_random_buffer(ref octet_queue q, input logic [7:0] host);
      octet_queue reply;
      int         shape;
      int         echo_len;
      int         len;
      bit         with_echo;
      q.delete();
      shape = $urandom_range(99);
      if (shape < 10) begin
         len = $urandom_range(1, 10);
         repeat (len) q.push_back(8'($urandom));
         return;
      end
      if (shape < 18) begin
         // echo declared longer than the buffer holds
         q.push_back(host);
         q.push_back(8'($urandom_range(8, 255)));
         repeat ($urandom_range(0, 8)) q.push_back(8'($urandom));
         return;
      end
      with_echo = $urandom_range(1);
      if (with_echo) begin
         echo_len = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
         q.push_back(host);
         q.push_back(8'(echo_len));
         repeat (echo_len + ECHO_OVERHEAD - ECHO_SEEN_AT_LEN) q.push_back(8'($urandom));
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      reply.push_back(with_echo ? 8'($urandom) : pick_source(host));
      reply.push_back(8'(len));
      reply.push_back(8'($urandom));
      reply.push_back(8'($urandom));
      repeat (len) reply.push_back(8'($urandom));
      append_checksum(reply);
      if ($urandom_range(5) == 0)
         reply[reply.size() - 1] = reply[reply.size() - 1] ^ 8'($urandom_range(1, 255));
      foreach (reply[i])
         q.push_back(reply[i]);
      // cut the buffer short now and then
      if ($urandom_range(7) == 0)
         q = q[0 : $urandom_range(0, q.size() - 2)];
   endfunction

   task automatic run_random_phase(input int bytes_wanted);
      octet_queue q;
      int         start;
      start = bytes_sent;
      while (bytes_sent - start < bytes_wanted) begin
         build_random_buffer(q, model.host_address);
         send_buffer(q);
      end
   endtask

   initial begin
      octet_queue q;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // One-byte echo, then a one-byte reply
      q = '{HOST_ADDRESS_RESET};
      send_buffer(q);
      q = '{8'h00};
      send_buffer(q);
      // Minimal good frame with one payload byte
      q = '{8'h01, 8'h01, 8'h02, 8'hFF, 8'hAA, 8'h53};
      send_buffer(q);
      // Echo followed by a reply with a bad checksum
      q = '{HOST_ADDRESS_RESET, 8'h00, 8'h01, 8'h80, 8'h7D,
            8'hFF, 8'h00, 8'h02, 8'h00, 8'h55};
      send_buffer(q);
      // Declared payload far past the received bytes
      q = '{8'h40, 8'hFF, 8'h00, 8'h80, 8'h11, 8'hEE};
      send_buffer(q);

      settle_block();
      write_host_address(8'h00);
      run_random_phase(PHASE_BYTES);

      settle_block();
      write_host_address(8'hFF);
      sender_idle_pct = 87;
      recv_idle_pct   = 33;
      run_random_phase(PHASE_BYTES);

      settle_block();
      write_host_address(8'($urandom));
      sender_idle_pct = 0;
      recv_idle_pct   = 0;

      // Overlong buffer under a long receiver hold-off
      q.delete();
      q.push_back(pick_source(model.host_address));
      q.push_back(8'(LONG_PAYLOAD));
      q.push_back(8'($urandom));
      q.push_back(8'($urandom));
      repeat (LONG_PAYLOAD) q.push_back(8'($urandom));
      append_checksum(q);
      repeat (SPILL_BYTES) q.push_back(8'($urandom));
      hold_requests++;
      send_buffer(q);
      run_random_phase(PHASE_BYTES);

      settle_block();
      if (model.mismatches == 0 && model.owed_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/srfp_pkg.sv
rtl/core/srfp_frame.sv
rtl/core/srfp_queue.sv
rtl/core/serial_reply_frame_parser_unit.sv
bench/serial_reply_frame_parser_unit_tb.sv
